// ===== hw/rtl/median_hysteresis_frequency_filter_macros.svh =====
// assertion macros for the median hysteresis frequency filter
// used by the top level; depends on nothing else
`ifndef MEDIAN_HYSTERESIS_FREQUENCY_FILTER_MACROS_SVH
`define MEDIAN_HYSTERESIS_FREQUENCY_FILTER_MACROS_SVH

// same-cycle implication, quiet during reset
`define MHFF_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet during reset
`define MHFF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/mhff_pkg.sv =====
// shared types and constants of the median hysteresis frequency filter
// no dependencies
`default_nettype none

package mhff_pkg;

  localparam int FREQ_W     = 32;
  localparam int SCALE_W    = 16;
  localparam int COUNT_W    = 16;
  localparam int PPM_W      = 18;
  localparam int FACT_W     = 21;
  localparam int PROD_W     = FREQ_W + FACT_W;
  localparam int NS_W       = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int QUOT_W     = 34;
  localparam int RECIP_W    = 32;
  localparam int RECIP_SHIFT = 30;

  localparam logic [FREQ_W-1:0] DIVISOR  = 32'd1000000;
  localparam logic [FACT_W-1:0] PPM_UNIT = 21'd1000000;

  // floor(2^51 / 1e6); top 32 product bits times this, shifted by 30,
  // undershoots the quotient by at most 7
  localparam logic [RECIP_W-1:0] RECIP   = 32'd2251799813;
  localparam logic [FREQ_W-1:0]  REM_MAX = 32'd8000000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_SCALE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PPM         = 3'd4;

  // register reset values
  localparam logic [SCALE_W-1:0] RST_COUNT_SCALE = 16'd2000;
  localparam logic [FREQ_W-1:0]  RST_LOWER_LIMIT = 32'd1000000;
  localparam logic [FREQ_W-1:0]  RST_UPPER_LIMIT = 32'd52000000;
  localparam logic [FREQ_W-1:0]  RST_HYSTERESIS  = 32'd10000;
  localparam logic [PPM_W-1:0]   RST_PPM         = 18'd1;

  typedef enum logic [4:0] {
    S_IDLE,
    S_MUL,
    S_LOW,
    S_HIGH,
    S_CRD,
    S_CLD,
    S_SRD,
    S_SCMP,
    S_SEL,
    S_DEV1,
    S_DEV2,
    S_HYS,
    S_PMUL,
    S_REC,
    S_QEST,
    S_REM,
    S_DIV,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic borrow;
    logic zero;
  } sub_flags_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mhff_sub.sv =====
// shared 32-bit subtract and compare unit
// depends on mhff_pkg
`default_nettype none

module mhff_sub (
  input  wire logic [mhff_pkg::FREQ_W-1:0] a,
  input  wire logic [mhff_pkg::FREQ_W-1:0] b,
  output logic      [mhff_pkg::FREQ_W-1:0] diff,
  output mhff_pkg::sub_flags_t             flags
);

  logic [mhff_pkg::FREQ_W:0] full;

  // borrow set means a < b
  assign full         = {1'b0, a} - {1'b0, b};
  assign diff         = full[mhff_pkg::FREQ_W-1:0];
  assign flags.borrow = full[mhff_pkg::FREQ_W];
  assign flags.zero   = (diff == '0);

endmodule

`default_nettype wire

// ===== hw/rtl/mhff_store.sv =====
// sample store: one write port, one registered read port
// depends on mhff_pkg
`default_nettype none

module mhff_store #(
  parameter int DEPTH = 5,
  parameter int AW    = 3
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [AW-1:0]               waddr,
  input  wire logic [mhff_pkg::FREQ_W-1:0] wdata,
  input  wire logic [AW-1:0]               raddr,
  output logic      [mhff_pkg::FREQ_W-1:0] rdata
);

  logic [mhff_pkg::FREQ_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/median_hysteresis_frequency_filter.sv =====
// Median frequency filter with hysteresis and ppm gain correction.
//
// Input channel (in_valid/in_ready, edge_count): one beat per gate period.
// Each beat is scaled by count_scale and kept if strictly between the
// lower and upper limits. The block takes a beat only while idle; it is
// not ready while it works on one.
// After every WINDOW beats one result beat leaves on the output channel
// (out_valid/out_ready, frequency_hz, valid_samples, stable_updated).
// The end of a window adds, for the n kept samples, rank counting through the
// single store read port and the shared subtract unit, a hysteresis check,
// a ppm multiply, a reciprocal multiply and remainder for the divide by one
// million, compare and subtract steps on the shared unit to correct the
// quotient and a load of the output register. An empty window goes straight
// to that load.
// The output register lets new beats be taken while a result waits; if
// the receiver still stalls when the next window ends, the block holds
// the new result and stops taking beats until the old one is taken.
// Reset (rst, synchronous) restores the register defaults, empties the
// window and clears the stable frequency. cfg_we writes one register per
// cycle and should only be used while the block is idle.
`default_nettype none

`include "median_hysteresis_frequency_filter_macros.svh"

module median_hysteresis_frequency_filter #(
  parameter int WINDOW = 5
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [mhff_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mhff_pkg::FREQ_W-1:0]      cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [mhff_pkg::COUNT_W-1:0]     edge_count,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [mhff_pkg::FREQ_W-1:0]      frequency_hz,
  output logic      [mhff_pkg::NS_W-1:0]        valid_samples,
  output logic                                  stable_updated
);

  localparam int CW = $clog2(WINDOW + 1);
  localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  // configuration
  logic [mhff_pkg::SCALE_W-1:0] count_scale;
  logic [mhff_pkg::FREQ_W-1:0]  lower_limit;
  logic [mhff_pkg::FREQ_W-1:0]  upper_limit;
  logic [mhff_pkg::FREQ_W-1:0]  hysteresis;
  logic [mhff_pkg::PPM_W-1:0]   ppm;

  mhff_pkg::state_t state, state_next;

  // window control
  logic [CW-1:0] slot_index;
  logic [CW-1:0] kept_count;
  logic [CW-1:0] n_q;
  logic [CW-1:0] lt_cnt;
  logic [CW-1:0] eq_cnt;
  logic [AW-1:0] cand_idx;
  logic [AW-1:0] scan_idx;

  // datapath
  logic [mhff_pkg::COUNT_W-1:0] cnt_q;
  logic [mhff_pkg::FREQ_W-1:0]  sample;
  logic                         above_low;
  logic [mhff_pkg::FREQ_W-1:0]  cand;
  logic [mhff_pkg::FREQ_W-1:0]  dev;
  logic                         dev_neg;
  logic [mhff_pkg::FREQ_W-1:0]  stable_frequency;
  logic                         upd_q;
  logic [mhff_pkg::PROD_W-1:0]  prod;
  logic [mhff_pkg::FREQ_W+mhff_pkg::RECIP_W-1:0] recip_prod;
  logic [mhff_pkg::QUOT_W-1:0]  quot;
  logic [mhff_pkg::FREQ_W-1:0]  qprod;
  logic [mhff_pkg::FREQ_W-1:0]  rem;

  // shared unit and store
  logic [mhff_pkg::FREQ_W-1:0] op_a;
  logic [mhff_pkg::FREQ_W-1:0] op_b;
  logic [mhff_pkg::FREQ_W-1:0] diff;
  mhff_pkg::sub_flags_t        flags;
  logic                        store_we;
  logic [AW-1:0]               store_raddr;
  logic [mhff_pkg::FREQ_W-1:0] store_rdata;

  logic                        keep;
  logic                        window_end;
  logic [CW-1:0]               n_next;
  logic                        scan_last;
  logic                        found;
  logic [CW-1:0]               mid;
  logic [CW-1:0]               lt_eq;
  logic                        out_free;
  logic [mhff_pkg::FACT_W-1:0] factor;
  logic                        upd;

  mhff_sub u_sub (
    .a     (op_a),
    .b     (op_b),
    .diff  (diff),
    .flags (flags)
  );

  mhff_store #(
    .DEPTH (WINDOW),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (kept_count[AW-1:0]),
    .wdata (sample),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  // status terms
  assign keep       = above_low && flags.borrow && (kept_count < CW'(WINDOW));
  assign window_end = (slot_index == CW'(WINDOW - 1));
  assign n_next     = kept_count + CW'(keep);
  assign scan_last  = (CW'(scan_idx) == n_q - 1'b1);
  assign mid        = n_q >> 1;
  assign lt_eq      = lt_cnt + eq_cnt;
  // candidate is the median when its rank range covers index n/2
  assign found      = (lt_cnt <= mid) && (mid < lt_eq);
  assign out_free   = !out_valid || out_ready;
  assign factor     = mhff_pkg::PPM_UNIT
                    + {{(mhff_pkg::FACT_W - mhff_pkg::PPM_W){ppm[mhff_pkg::PPM_W-1]}}, ppm};
  assign upd        = (stable_frequency == '0) || flags.borrow;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mhff_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = mhff_pkg::S_MUL;
        end
      end
      mhff_pkg::S_MUL:  state_next = mhff_pkg::S_LOW;
      mhff_pkg::S_LOW:  state_next = mhff_pkg::S_HIGH;
      mhff_pkg::S_HIGH: begin
        if (!window_end) begin
          state_next = mhff_pkg::S_IDLE;
        end else if (n_next == '0) begin
          state_next = mhff_pkg::S_EMIT;
        end else begin
          state_next = mhff_pkg::S_CRD;
        end
      end
      mhff_pkg::S_CRD:  state_next = mhff_pkg::S_CLD;
      mhff_pkg::S_CLD:  state_next = mhff_pkg::S_SRD;
      mhff_pkg::S_SRD:  state_next = mhff_pkg::S_SCMP;
      mhff_pkg::S_SCMP: state_next = scan_last ? mhff_pkg::S_SEL : mhff_pkg::S_SRD;
      mhff_pkg::S_SEL:  state_next = found ? mhff_pkg::S_DEV1 : mhff_pkg::S_CRD;
      mhff_pkg::S_DEV1: state_next = mhff_pkg::S_DEV2;
      mhff_pkg::S_DEV2: state_next = mhff_pkg::S_HYS;
      mhff_pkg::S_HYS:  state_next = mhff_pkg::S_PMUL;
      mhff_pkg::S_PMUL: state_next = mhff_pkg::S_REC;
      mhff_pkg::S_REC:  state_next = mhff_pkg::S_QEST;
      mhff_pkg::S_QEST: state_next = mhff_pkg::S_REM;
      mhff_pkg::S_REM:  state_next = mhff_pkg::S_DIV;
      mhff_pkg::S_DIV:  state_next = flags.borrow ? mhff_pkg::S_EMIT : mhff_pkg::S_DIV;
      mhff_pkg::S_EMIT: state_next = out_free ? mhff_pkg::S_IDLE : mhff_pkg::S_EMIT;
      default:          state_next = mhff_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs: handshake, store port, shared unit operands
  always_comb begin
    in_ready    = (state == mhff_pkg::S_IDLE);
    store_we    = (state == mhff_pkg::S_HIGH) && keep;
    store_raddr = (state == mhff_pkg::S_SRD) ? scan_idx : cand_idx;
    op_a        = '0;
    op_b        = '0;
    case (state)
      mhff_pkg::S_LOW: begin
        op_a = lower_limit;
        op_b = sample;
      end
      mhff_pkg::S_HIGH: begin
        op_a = sample;
        op_b = upper_limit;
      end
      mhff_pkg::S_SCMP: begin
        op_a = store_rdata;
        op_b = cand;
      end
      mhff_pkg::S_DEV1: begin
        op_a = cand;
        op_b = stable_frequency;
      end
      mhff_pkg::S_DEV2: begin
        op_a = stable_frequency;
        op_b = cand;
      end
      mhff_pkg::S_HYS: begin
        op_a = hysteresis;
        op_b = dev;
      end
      mhff_pkg::S_REM: begin
        // remainder is small, so the low words alone give it exactly
        op_a = prod[mhff_pkg::FREQ_W-1:0];
        op_b = qprod;
      end
      mhff_pkg::S_DIV: begin
        op_a = rem;
        op_b = mhff_pkg::DIVISOR;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mhff_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_scale <= mhff_pkg::RST_COUNT_SCALE;
      lower_limit <= mhff_pkg::RST_LOWER_LIMIT;
      upper_limit <= mhff_pkg::RST_UPPER_LIMIT;
      hysteresis  <= mhff_pkg::RST_HYSTERESIS;
      ppm         <= mhff_pkg::RST_PPM;
    end else if (cfg_we) begin
      case (cfg_index)
        mhff_pkg::REG_COUNT_SCALE: count_scale <= cfg_data[mhff_pkg::SCALE_W-1:0];
        mhff_pkg::REG_LOWER_LIMIT: lower_limit <= cfg_data;
        mhff_pkg::REG_UPPER_LIMIT: upper_limit <= cfg_data;
        mhff_pkg::REG_HYSTERESIS:  hysteresis  <= cfg_data;
        mhff_pkg::REG_PPM:         ppm         <= cfg_data[mhff_pkg::PPM_W-1:0];
        default: ;
      endcase
    end
  end

  // window counters and stable value
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_index       <= '0;
      kept_count       <= '0;
      stable_frequency <= '0;
    end else begin
      if (state == mhff_pkg::S_HIGH) begin
        if (window_end) begin
          slot_index <= '0;
          kept_count <= '0;
        end else begin
          slot_index <= slot_index + 1'b1;
          kept_count <= n_next;
        end
      end
      if (state == mhff_pkg::S_HYS && upd) begin
        stable_frequency <= cand;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      mhff_pkg::S_IDLE: begin
        cnt_q <= edge_count;
      end
      mhff_pkg::S_MUL: begin
        sample <= {{(mhff_pkg::FREQ_W - mhff_pkg::COUNT_W){1'b0}}, cnt_q}
                * {{(mhff_pkg::FREQ_W - mhff_pkg::SCALE_W){1'b0}}, count_scale};
      end
      mhff_pkg::S_LOW: begin
        above_low <= flags.borrow;
      end
      mhff_pkg::S_HIGH: begin
        n_q      <= n_next;
        cand_idx <= '0;
        // empty window yields zero and no update
        quot     <= '0;
        upd_q    <= 1'b0;
      end
      mhff_pkg::S_CLD: begin
        cand     <= store_rdata;
        scan_idx <= '0;
        lt_cnt   <= '0;
        eq_cnt   <= '0;
      end
      mhff_pkg::S_SCMP: begin
        lt_cnt   <= lt_cnt + CW'(flags.borrow);
        eq_cnt   <= eq_cnt + CW'(flags.zero);
        scan_idx <= scan_idx + 1'b1;
      end
      mhff_pkg::S_SEL: begin
        if (!found) begin
          cand_idx <= cand_idx + 1'b1;
        end
      end
      mhff_pkg::S_DEV1: begin
        dev     <= diff;
        dev_neg <= flags.borrow;
      end
      mhff_pkg::S_DEV2: begin
        if (dev_neg) begin
          dev <= diff;
        end
      end
      mhff_pkg::S_HYS: begin
        upd_q <= upd;
      end
      mhff_pkg::S_PMUL: begin
        prod <= {{mhff_pkg::FACT_W{1'b0}}, stable_frequency}
              * {{mhff_pkg::FREQ_W{1'b0}}, factor};
      end
      mhff_pkg::S_REC: begin
        // top 32 bits of the product times the reciprocal of one million
        recip_prod <= {{mhff_pkg::RECIP_W{1'b0}},
                       prod[mhff_pkg::PROD_W-1 -: mhff_pkg::FREQ_W]}
                    * {{mhff_pkg::FREQ_W{1'b0}}, mhff_pkg::RECIP};
      end
      mhff_pkg::S_QEST: begin
        // quotient estimate, low word of estimate times one million
        quot  <= recip_prod[mhff_pkg::RECIP_SHIFT +: mhff_pkg::QUOT_W];
        qprod <= mhff_pkg::FREQ_W'(recip_prod[mhff_pkg::RECIP_SHIFT +: mhff_pkg::QUOT_W]
                                   * mhff_pkg::QUOT_W'(mhff_pkg::DIVISOR));
      end
      mhff_pkg::S_REM: begin
        rem <= diff;
      end
      mhff_pkg::S_DIV: begin
        // estimate runs low, step it up while the remainder allows
        if (!flags.borrow) begin
          rem  <= diff;
          quot <= quot + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == mhff_pkg::S_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == mhff_pkg::S_EMIT && out_free) begin
      if (quot[mhff_pkg::QUOT_W-1:mhff_pkg::FREQ_W] != '0) begin
        frequency_hz <= '1;
      end else begin
        frequency_hz <= quot[mhff_pkg::FREQ_W-1:0];
      end
      valid_samples  <= mhff_pkg::NS_W'(n_q);
      stable_updated <= upd_q;
    end
  end

  `MHFF_ASSERT_IMPL(a_kept_le_slot, clk, rst, 1'b1, kept_count <= slot_index,
    "kept sample count exceeds beats taken in window")
  `MHFF_ASSERT_NEXT(a_busy_after_beat, clk, rst, in_valid && in_ready, !in_ready,
    "input taken on consecutive cycles")
  `MHFF_ASSERT_IMPL(a_rem_bound, clk, rst, state == mhff_pkg::S_DIV, rem < mhff_pkg::REM_MAX,
    "divide remainder out of range")
  `MHFF_ASSERT_IMPL(a_upd_nonzero, clk, rst, out_valid && stable_updated,
    stable_frequency != '0, "stable frequency zero after update")
  `MHFF_ASSERT_IMPL(a_rise_from_emit, clk, rst, $rose(out_valid),
    $past(state == mhff_pkg::S_EMIT), "result beat raised outside emit")

endmodule

`default_nettype wire

// ===== test/freq_filter_checker.sv =====
// checker for the median hysteresis frequency filter: watches config writes and both channels,
// predicts each window result and compares it field by field
// depends on mhff_pkg for widths, register indexes and reset values
module freq_filter_checker
  import mhff_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FREQ_W-1:0]    cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [COUNT_W-1:0]   edge_count,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [FREQ_W-1:0]    frequency_hz,
  input  logic [NS_W-1:0]      valid_samples,
  input  logic                 stable_updated,
  output int                   errors,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW_LEN = 5;

  typedef struct {
    logic [FREQ_W-1:0] freq;
    logic [NS_W-1:0]   kept;
    logic              upd;
  } window_result_t;

  window_result_t expected_windows[$];

  // register copies
  logic [SCALE_W-1:0]       scale_q;
  logic [FREQ_W-1:0]        lower_q, upper_q, hyst_q;
  logic signed [PPM_W-1:0]  ppm_q;

  // filter state
  logic [FREQ_W-1:0] kept_hz [WINDOW_LEN];
  int                slot_cnt;
  int                kept_n;
  logic [FREQ_W-1:0] stable_hz;

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic flag_mismatch(input string what);
    $display("%0t checker: %s", $realtime, what);
    errors++;
  endtask

  task automatic absorb_count(input logic [COUNT_W-1:0] cnt);
    logic [FREQ_W-1:0] sample, median, dev, swap;
    logic [FREQ_W-1:0] sorted [WINDOW_LEN];
    longint unsigned   wide_hz, gain, corrected;
    window_result_t    res;
    int                n, a, b;
    sample = 32'(cnt) * 32'(scale_q);
    if (sample > lower_q && sample < upper_q && kept_n < WINDOW_LEN) begin
      kept_hz[kept_n] = sample;
      kept_n++;
    end
    slot_cnt++;
    if (slot_cnt < WINDOW_LEN) return;
    n = kept_n;
    slot_cnt = 0;
    kept_n = 0;
    res.freq = '0;
    res.kept = NS_W'(n);
    res.upd  = 1'b0;
    // empty window: zero out, stable value untouched
    if (n != 0) begin
      sorted = kept_hz;
      for (a = 0; a + 1 < n; a++) begin
        for (b = a + 1; b < n; b++) begin
          if (sorted[a] > sorted[b]) begin
            swap = sorted[a];
            sorted[a] = sorted[b];
            sorted[b] = swap;
          end
        end
      end
      median = sorted[n / 2];
      dev = (median > stable_hz) ? median - stable_hz : stable_hz - median;
      if (stable_hz == 0 || dev > hyst_q) begin
        stable_hz = median;
        res.upd = 1'b1;
      end
      // 1e6 + ppm stays positive over the whole register range
      wide_hz   = stable_hz;
      gain      = longint'(ppm_q) + longint'(PPM_UNIT);
      corrected = wide_hz * gain / DIVISOR;
      res.freq  = (corrected > 64'hFFFF_FFFF) ? '1 : corrected[FREQ_W-1:0];
    end
    expected_windows.push_back(res);
  endtask

  always @(posedge clk) begin
    window_result_t want;
    if (rst) begin
      scale_q   = RST_COUNT_SCALE;
      lower_q   = RST_LOWER_LIMIT;
      upper_q   = RST_UPPER_LIMIT;
      hyst_q    = RST_HYSTERESIS;
      ppm_q     = RST_PPM;
      slot_cnt  = 0;
      kept_n    = 0;
      stable_hz = '0;
      expected_windows.delete();
    end else begin
      // result beat first: it always belongs to an earlier window
      if (out_valid && out_ready) begin
        if (expected_windows.size() == 0) begin
          flag_mismatch($sformatf("result beat with nothing expected, freq %0d", frequency_hz));
        end else begin
          want = expected_windows.pop_front();
          if (frequency_hz !== want.freq)
            flag_mismatch($sformatf("frequency_hz %0d, want %0d", frequency_hz, want.freq));
          if (valid_samples !== want.kept)
            flag_mismatch($sformatf("valid_samples %0d, want %0d", valid_samples, want.kept));
          if (stable_updated !== want.upd)
            flag_mismatch($sformatf("stable_updated %0b, want %0b", stable_updated, want.upd));
        end
      end
      if (in_valid && in_ready) absorb_count(edge_count);
      if (cfg_we) begin
        case (cfg_index)
          REG_COUNT_SCALE: scale_q = cfg_data[SCALE_W-1:0];
          REG_LOWER_LIMIT: lower_q = cfg_data;
          REG_UPPER_LIMIT: upper_q = cfg_data;
          REG_HYSTERESIS:  hyst_q  = cfg_data;
          REG_PPM:         ppm_q   = cfg_data[PPM_W-1:0];
          default: ;
        endcase
      end
    end
    pending = expected_windows.size();
  end

endmodule

// ===== test/tb_top.sv =====
// top of the median hysteresis frequency filter testbench: clock, reset, config phases,
// edge count stimulus and receiver stalls; freq_filter_checker does the predicting
// depends on mhff_pkg, freq_filter_checker and the filter RTL
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mhff_pkg::*;

  localparam int SETTLE_CYCLES = 200;
  localparam int NUM_PHASES    = 9;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef struct {
    logic [SCALE_W-1:0] scale;
    logic [FREQ_W-1:0]  lower;
    logic [FREQ_W-1:0]  upper;
    logic [FREQ_W-1:0]  hyst;
    int                 ppm;
  } filter_setting_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [FREQ_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [COUNT_W-1:0]   edge_count = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [FREQ_W-1:0]    frequency_hz;
  logic [NS_W-1:0]      valid_samples;
  logic                 stable_updated;
  int                   mismatch_count;
  int                   windows_pending;

  bit gaps_on = 1'b1;
  int stall_left = 0;

  median_hysteresis_frequency_filter dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .edge_count    (edge_count),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .frequency_hz  (frequency_hz),
    .valid_samples (valid_samples),
    .stable_updated(stable_updated)
  );

  freq_filter_checker chk (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .edge_count    (edge_count),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .frequency_hz  (frequency_hz),
    .valid_samples (valid_samples),
    .stable_updated(stable_updated),
    .errors        (mismatch_count),
    .pending       (windows_pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver stalls in random bursts while gaps are on
  always @(posedge clk) begin
    if (stall_left == 0 && gaps_on && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 3);
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    #5ms;
    $display("tb_top: errors");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FREQ_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // valid may stay high across back-to-back beats; here only an idle burst lowers it
  task automatic send_count(input int cnt);
    int idle;
    idle = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid   <= 1'b1;
    edge_count <= COUNT_W'(cnt);
    do @(posedge clk); while (!in_ready);
  endtask

  // all results in, then let a partial window finish its beat
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (windows_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_center(input longint lo, input longint hi);
    if ($urandom_range(0, 3) == 0) return 65535 - int'($urandom_range(0, 300));
    if (lo > hi) return int'($urandom_range(0, 65535));
    return int'($urandom_range(32'(lo), 32'(hi)));
  endfunction

  initial begin
    int              directed_counts[25];
    filter_setting_t cfg_set;
    longint          lo_cnt, hi_cnt;
    int              phase, n_items, i, center, spread, cnt, pick;

    // rejected at both limits, empty windows, hysteresis edge and step
    directed_counts = '{0, 500, 501, 25999, 26000,
                        0, 0, 0, 0, 0,
                        65535, 65535, 65535, 65535, 65535,
                        25994, 25994, 25994, 1, 2,
                        25993, 25993, 25993, 25993, 25993};

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_reg(REG_UNMAPPED, '1);
    cfg_we <= 1'b0;
    @(posedge clk);
    foreach (directed_counts[k]) send_count(directed_counts[k]);

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      settle();
      case (phase)
        0: cfg_set = '{16'd1, 32'd0, 32'hFFFF_FFFF, 32'd0, 0};
        1: cfg_set = '{16'hFFFF, 32'd0, 32'hFFFF_FFFF, 32'd1000, 100000};
        2: cfg_set = '{16'hFFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, -100000};
        3: cfg_set = '{16'd3000, 32'd52000000, 32'd1000000, 32'd500, 50};
        4: cfg_set = '{16'd2000, 32'd50000000, 32'd50000000, 32'd0, -1};
        5: cfg_set = '{16'd2000, 32'd1000000, 32'd52000000, 32'd10000, 1};
        default: begin
          cfg_set.scale = SCALE_W'($urandom_range(1, 65535));
          cfg_set.lower = $urandom();
          cfg_set.upper = $urandom();
          if (cfg_set.lower > cfg_set.upper && $urandom_range(0, 3) != 0) begin
            cfg_set.hyst  = cfg_set.lower;
            cfg_set.lower = cfg_set.upper;
            cfg_set.upper = cfg_set.hyst;
          end
          cfg_set.hyst = $urandom_range(0, 1 << 20);
          cfg_set.ppm  = int'($urandom_range(0, 200000)) - 100000;
        end
      endcase
      write_reg(REG_COUNT_SCALE, FREQ_W'(cfg_set.scale));
      write_reg(REG_LOWER_LIMIT, cfg_set.lower);
      write_reg(REG_UPPER_LIMIT, cfg_set.upper);
      write_reg(REG_HYSTERESIS, cfg_set.hyst);
      write_reg(REG_PPM, FREQ_W'(cfg_set.ppm));
      cfg_we <= 1'b0;
      @(posedge clk);

      // last phase runs with no idling on either side
      gaps_on = (phase == NUM_PHASES - 1) ? 1'b0 : 1'(($urandom_range(0, 2) != 0));
      lo_cnt = longint'(cfg_set.lower) / longint'(cfg_set.scale) + 1;
      hi_cnt = (cfg_set.upper == 0) ? -1
             : (longint'(cfg_set.upper) - 1) / longint'(cfg_set.scale);
      if (hi_cnt > 65535) hi_cnt = 65535;
      center  = pick_center(lo_cnt, hi_cnt);
      spread  = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 200);
      n_items = $urandom_range(40, 56);
      for (i = 0; i < n_items; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          cnt = int'($urandom_range(0, 65535));
        end else if (pick < 10) begin
          cnt = (pick == 8) ? 0 : 65535;
        end else begin
          // occasional step to a new frequency
          if (pick < 14) center = pick_center(lo_cnt, hi_cnt);
          cnt = center + int'($urandom_range(0, 2 * spread)) - spread;
          if (cnt < 0) cnt = 0;
          if (cnt > 65535) cnt = 65535;
        end
        send_count(cnt);
      end
    end

    settle();
    if (mismatch_count == 0 && windows_pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
